>>> design/modexp_pkg.sv
package modexp_pkg;

    // Width of every operand port; the datapath uses the low bits only
    localparam int FIELD_WIDTH = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE     = 3'b001,
        ST_SQUARE   = 3'b010,
        ST_MULTIPLY = 3'b100
    } modexp_state_t;

endpackage

>>> design/modexp_mul.sv
module modexp_mul #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     mul_start,
    input  logic [OPERAND_WIDTH-1:0] multiplicand,
    input  logic [OPERAND_WIDTH-1:0] multiplier,
    input  logic [OPERAND_WIDTH-1:0] modulus_value,
    output logic                     mul_done,
    output logic [OPERAND_WIDTH-1:0] product
);

    import modexp_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    // (x + y) mod m for x, y < m: one add, one compare-subtract
    function automatic logic [W-1:0] add_reduce(
        input logic [W-1:0] x,
        input logic [W-1:0] y,
        input logic [W-1:0] m
    );
        logic [W:0]   sum;
        logic [W+1:0] diff;
        sum  = {1'b0, x} + {1'b0, y};
        diff = {1'b0, sum} - {2'b00, m};
        if (diff[W+1])
        begin
            return sum[W-1:0];
        end
        return diff[W-1:0];
    endfunction

    logic [W-1:0]     acc_reg, acc_next;
    logic [W-1:0]     addend_reg, addend_next;
    logic [W-1:0]     mult_reg, mult_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    // One multiplier bit per cycle, LSB first
    always_comb
    begin
        acc_next    = acc_reg;
        addend_next = addend_reg;
        mult_next   = mult_reg;
        cnt_next    = cnt_reg;
        run_next    = run_reg;
        done_next   = 1'b0;
        if (mul_start)
        begin
            acc_next    = '0;
            addend_next = multiplicand;
            mult_next   = multiplier;
            cnt_next    = CNT_W'(W - 1);
            run_next    = 1'b1;
        end
        else if (run_reg)
        begin
            if (mult_reg[0])
            begin
                acc_next = add_reduce(acc_reg, addend_reg, modulus_value);
            end
            addend_next = add_reduce(addend_reg, addend_reg, modulus_value);
            mult_next   = mult_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        addend_reg <= addend_next;
        mult_reg   <= mult_next;
        cnt_reg    <= cnt_next;
    end

    assign mul_done = done_reg;
    assign product  = acc_reg;

endmodule

>>> design/modular_exponentiation.sv
// Left-to-right binary modular exponentiation. Write the modulus on the
// cfg_valid/cfg_ready channel while busy and start are low (reset value 1), then
// pulse start with base_value and exponent_value; the transfer happens when start
// is high and busy low. Only the low OPERAND_WIDTH bits of every operand are used.
// The result appears on power_result/modulus_error for exactly one cycle with
// done high and must be taken then; the receiver cannot stall it. Each modular
// multiply runs through a bit-serial shift-and-add unit that consumes one
// multiplier bit per cycle; an item needs one squaring per exponent bit plus
// one multiply per set exponent bit. A zero modulus returns zero with
// modulus_error set in the cycle after the transfer.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] modulus,
    input  logic                              start,
    output logic                              busy,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] base_value,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0] exponent_value,
    output logic                              done,
    output logic [modexp_pkg::FIELD_WIDTH-1:0] power_result,
    output logic                              modulus_error
);

    import modexp_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    modexp_state_t    state_reg, state_next;
    logic [W-1:0]     mod_reg, mod_next;
    logic [W-1:0]     base_reg, base_next;
    logic [W-1:0]     exp_reg, exp_next;
    logic [W-1:0]     r_reg, r_next;
    logic [W-1:0]     result_reg, result_next;
    logic [CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             error_reg, error_next;
    logic             done_reg, done_next;
    logic             mul_start_reg, mul_start_next;

    logic             mul_done;
    logic [W-1:0]     product;
    logic [W-1:0]     mul_y;
    logic             accept;

    // An item transfer takes priority over a modulus write on the same edge
    assign accept    = start && (state_reg == ST_IDLE);
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE) && !start;

    // Second operand: the base on a multiply step, the running value otherwise
    assign mul_y = (state_reg == ST_MULTIPLY) ? base_reg : r_reg;

    modexp_mul #(
        .OPERAND_WIDTH (W)
    ) u_mul (
        .clk           (clk),
        .rst_n         (rst_n),
        .mul_start     (mul_start_reg),
        .multiplicand  (r_reg),
        .multiplier    (mul_y),
        .modulus_value (mod_reg),
        .mul_done      (mul_done),
        .product       (product)
    );

    // Sequencer: square per exponent bit, multiply on a one bit
    always_comb
    begin
        state_next     = state_reg;
        mod_next       = mod_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        r_next         = r_reg;
        result_next    = result_reg;
        bit_cnt_next   = bit_cnt_reg;
        error_next     = error_reg;
        done_next      = 1'b0;
        mul_start_next = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            mod_next = modulus[W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next    = base_value[W-1:0];
                    exp_next     = exponent_value[W-1:0];
                    bit_cnt_next = CNT_W'(W - 1);
                    if (mod_reg == '0)
                    begin
                        result_next = '0;
                        error_next  = 1'b1;
                        done_next   = 1'b1;
                    end
                    else
                    begin
                        // running value starts at 1 mod m
                        r_next         = {{(W-1){1'b0}}, (mod_reg != W'(1))};
                        error_next     = 1'b0;
                        mul_start_next = 1'b1;
                        state_next     = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE, ST_MULTIPLY:
            begin
                if (mul_done)
                begin
                    r_next = product;
                    if ((state_reg == ST_SQUARE) && exp_reg[W-1])
                    begin
                        mul_start_next = 1'b1;
                        state_next     = ST_MULTIPLY;
                    end
                    else if (bit_cnt_reg == '0)
                    begin
                        result_next = product;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        exp_next       = exp_reg << 1;
                        bit_cnt_next   = bit_cnt_reg - 1'b1;
                        mul_start_next = 1'b1;
                        state_next     = ST_SQUARE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and the modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mod_reg       <= W'(1);
            done_reg      <= 1'b0;
            mul_start_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mod_reg       <= mod_next;
            done_reg      <= done_next;
            mul_start_reg <= mul_start_next;
        end
    end

    // Operand and result registers
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        r_reg       <= r_next;
        result_reg  <= result_next;
        bit_cnt_reg <= bit_cnt_next;
        error_reg   <= error_next;
    end

    assign done          = done_reg;
    assign power_result  = FIELD_WIDTH'(result_reg);
    assign modulus_error = error_reg;

endmodule

>>> design/modexp_checker.sv
module modexp_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [modexp_pkg::FIELD_WIDTH-1:0] power_result,
    input logic                              modulus_error
);

    import modexp_pkg::*;

    // An errored result carries zero
    property p_error_zero;
        @(posedge clk) disable iff (!rst_n)
            (done && modulus_error) |-> (power_result == '0);
    endproperty
    a_error_zero: assert property (p_error_zero)
        else $error("modulus error result is not zero");

    // A transfer either starts work or returns the error result next cycle
    property p_accept_progress;
        @(posedge clk) disable iff (!rst_n)
            (start && !busy) |=> (busy || (done && modulus_error));
    endproperty
    a_accept_progress: assert property (p_accept_progress)
        else $error("accepted item neither started nor answered");

    // The block only goes idle when it delivers a result
    property p_idle_with_result;
        @(posedge clk) disable iff (!rst_n)
            $fell(busy) |-> done;
    endproperty
    a_idle_with_result: assert property (p_idle_with_result)
        else $error("busy dropped without a result");

    // No modulus write while an item is in flight
    property p_no_cfg_busy;
        @(posedge clk) disable iff (!rst_n)
            busy |-> !cfg_ready;
    endproperty
    a_no_cfg_busy: assert property (p_no_cfg_busy)
        else $error("configuration ready while busy");

    // A modulus write never shares an edge with an item transfer
    property p_cfg_not_with_start;
        @(posedge clk) disable iff (!rst_n)
            (cfg_valid && cfg_ready) |-> !(start && !busy);
    endproperty
    a_cfg_not_with_start: assert property (p_cfg_not_with_start)
        else $error("modulus write on the same edge as an item transfer");

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .power_result  (power_result),
    .modulus_error (modulus_error)
);

>>> tb/modular_exponentiation_tb.sv
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    import modexp_pkg::*;

    localparam int          W           = FIELD_WIDTH;
    localparam longint      CYCLE_LIMIT = 12_000_000;
    localparam logic [W-1:0] ALL_ONES   = '1;

    // One expected result
    typedef struct {
        logic [W-1:0] power;
        logic         err;
    } power_expect_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [W-1:0] modulus;
    logic         start;
    logic         busy;
    logic [W-1:0] base_value;
    logic [W-1:0] exponent_value;
    logic         done;
    logic [W-1:0] power_result;
    logic         modulus_error;

    // Predictor state and scoreboard
    logic [W-1:0]  modulus_setting;
    power_expect_t pending_powers[$];
    int            idle_pct;
    longint        cycle_count;
    int            results_checked;
    int            items_sent;
    int            error_items;
    int            modulus_writes;
    int            mismatches;

    modular_exponentiation dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .modulus        (modulus),
        .start          (start),
        .busy           (busy),
        .base_value     (base_value),
        .exponent_value (exponent_value),
        .done           (done),
        .power_result   (power_result),
        .modulus_error  (modulus_error)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Left-to-right square and multiply, exact products on 128 bits
    function automatic power_expect_t predict_power(logic [W-1:0] m, logic [W-1:0] b,
                                                    logic [W-1:0] e);
        power_expect_t res;
        logic [2*W-1:0] acc;
        acc = {{(2*W-1){1'b0}}, 1'b1};
        if (m == 0)
        begin
            res.power = '0;
            res.err   = 1'b1;
            return res;
        end
        for (int k = W - 1; k >= 0; k--)
        begin
            acc = (acc * acc) % {{W{1'b0}}, m};
            if (e[k])
                acc = (acc * {{W{1'b0}}, b}) % {{W{1'b0}}, m};
        end
        res.power = acc[W-1:0];
        res.err   = 1'b0;
        return res;
    endfunction

    // Operand mix: full random, small values, near the top
    function automatic logic [W-1:0] rand_operand();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return W'($urandom_range(0, 15));
        else if (pick == 2)
            return ALL_ONES - W'($urandom_range(0, 15));
        else
            return {$urandom, $urandom};
    endfunction

    function automatic logic [W-1:0] rand_modulus();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return W'(1);
        else if (pick < 5)
            return W'($urandom_range(2, 1000));
        else if (pick < 7)
            return ALL_ONES - W'($urandom_range(0, 100));
        else
            return {$urandom, $urandom};
    endfunction

    // Cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_powers.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result checker: every done pulse is one transfer
    always @(posedge clk)
    begin
        power_expect_t exp_res;
        if (rst_n && done)
        begin
            if (pending_powers.size() == 0)
            begin
                $error("result with nothing expected: power_result %h modulus_error %b",
                       power_result, modulus_error);
                mismatches++;
            end
            else
            begin
                exp_res = pending_powers.pop_front();
                results_checked++;
                if (power_result !== exp_res.power)
                begin
                    $error("power_result: expected %h, actual %h", exp_res.power, power_result);
                    mismatches++;
                end
                if (modulus_error !== exp_res.err)
                begin
                    $error("modulus_error: expected %b, actual %b", exp_res.err,
                           modulus_error);
                    mismatches++;
                end
            end
        end
    end

    // Send one item; start stays high after the transfer unless a gap follows
    task automatic send_item(logic [W-1:0] b, logic [W-1:0] e);
        power_expect_t exp_res;
        start          <= 1'b1;
        base_value     <= b;
        exponent_value <= e;
        do
            @(posedge clk);
        while (busy);
        exp_res = predict_power(modulus_setting, b, e);
        pending_powers.insert(pending_powers.size(), exp_res);
        items_sent++;
        if (exp_res.err)
            error_items++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 17000)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    endtask

    // Hold off until every expected result is back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_powers.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_modulus(logic [W-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        modulus   <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid       <= 1'b0;
        modulus_setting  = value;
        modulus_writes++;
    endtask

    // Reset value of the modulus is one: everything reduces to zero
    task automatic test_reset_modulus();
        send_item(ALL_ONES, ALL_ONES);
        send_item('0, '0);
    endtask

    // Field extremes, zero and unit modulus, carry path at a full-width modulus
    task automatic test_directed();
        write_modulus(ALL_ONES);
        send_item(ALL_ONES, W'(1));
        send_item(W'(2), ALL_ONES);
        send_item(ALL_ONES - 1, W'(2));
        send_item(W'(123456789), '0);

        write_modulus(ALL_ONES - 58);
        send_item(64'hDEAD_BEEF_0123_4567, ALL_ONES);
        send_item('0, W'(5));
        send_item('0, '0);

        write_modulus(W'(2));
        send_item(W'(3), W'(7));
        send_item(W'(4), W'(1));

        write_modulus('0);
        send_item(W'(5), W'(3));
        send_item(ALL_ONES, ALL_ONES);

        write_modulus(W'(1));
        send_item(W'(7), '0);

        write_modulus(64'h8000_0000_0000_0000);
        send_item(W'(3), 64'h8000_0000_0000_0001);
        send_item(64'h8000_0000_0000_0001, W'(2));

        write_modulus(W'(1000000007));
        send_item(W'(2), W'(1000000005));
        send_item(ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA);
    endtask

    // Random items in idling phases, with a new modulus every few items
    task automatic test_random_phases();
        int phase_pct[4];
        phase_pct = '{0, 68, 0, 15};
        foreach (phase_pct[p])
        begin
            idle_pct = phase_pct[p];
            for (int n = 0; n < 20; n++)
            begin
                if (n % 8 == 0)
                    write_modulus(rand_modulus());
                else if ($urandom_range(0, 9) == 0)
                    drain_results();
                send_item(rand_operand(), rand_operand());
            end
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        cfg_valid       <= 1'b0;
        modulus         <= '0;
        start           <= 1'b0;
        base_value      <= '0;
        exponent_value  <= '0;
        modulus_setting  = W'(1);
        idle_pct         = 0;
        cycle_count      = 0;
        results_checked  = 0;
        items_sent       = 0;
        error_items      = 0;
        modulus_writes   = 0;
        mismatches       = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_modulus();
        test_directed();
        test_random_phases();

        // Let the last results come back, then a short quiet window
        drain_results();
        repeat (50) @(posedge clk);

        $display("covered %0d items (%0d with zero modulus) over %0d modulus writes",
                 items_sent, error_items, modulus_writes);
        $display("checked %0d results, %0d field mismatches", results_checked, mismatches);
        if (mismatches == 0 && pending_powers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
